@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define OWZB_ASSERT_IMPLY(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, held off during reset.
`define OWZB_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

@@ hw/rtl/owzb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owzb_pkg
// Types and codes shared by the one-way zone blocker.
// ----------------------------------------------------------------------------
package owzb_pkg;

  localparam int CORNERS = 4;
  localparam int CW      = $clog2(CORNERS);

  localparam logic [2:0] CMD_CORNER = 3'd0;
  localparam logic [2:0] CMD_ENTRY  = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_MODE   = 3'd3;
  localparam logic [2:0] CMD_BLOCK  = 3'd4;
  localparam logic [2:0] CMD_UPDATE = 3'd5;
  localparam logic [2:0] CMD_QUERY  = 3'd6;

  localparam logic [1:0] MODE_FWD = 2'd1;
  localparam logic [1:0] MODE_REV = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic   vld;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
  } edge_in_t;

endpackage

@@ hw/rtl/owzb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owzb_cmd_if / owzb_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface owzb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [3:0]        zone;
  logic [1:0]        corner;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [1:0]        mode;
  logic signed [7:0] blocked_id;

  modport source (output valid, command, zone, corner, coord_x, coord_y, mode, blocked_id,
                  input ready);
  modport sink   (input valid, command, zone, corner, coord_x, coord_y, mode, blocked_id,
                  output ready);
endinterface

interface owzb_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] zone_index;
  logic       blocked;
  logic       lethal;
  logic       last;

  modport source (output valid, kind, zone_index, blocked, lethal, last, input ready);
  modport sink   (input valid, kind, zone_index, blocked, lethal, last, output ready);
endinterface

@@ hw/rtl/owzb_edge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owzb_edge
// Pipelined ray-crossing test per polygon edge with even-odd parity.
// ----------------------------------------------------------------------------
module owzb_edge (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  owzb_pkg::edge_in_t edge_in,
  output logic               in_zone
);
  import owzb_pkg::*;

  logic               a_vld;
  logic               a_cond;
  logic signed [32:0] a_dbx, a_pya, a_pxa, a_d;
  logic               b_vld;
  logic               b_cond;
  logic               b_dpos;
  logic signed [65:0] b_p1, b_p2;
  logic signed [66:0] diff;
  logic               toggle;

  always_ff @(posedge clk) begin
    a_cond <= (edge_in.ay > edge_in.py) != (edge_in.by > edge_in.py);
    a_dbx  <= 33'(edge_in.bx) - 33'(edge_in.ax);
    a_pya  <= 33'(edge_in.py) - 33'(edge_in.ay);
    a_pxa  <= 33'(edge_in.px) - 33'(edge_in.ax);
    a_d    <= 33'(edge_in.by) - 33'(edge_in.ay);
    b_cond <= a_cond;
    b_dpos <= a_d > 33'sd0;
    b_p1   <= a_dbx * a_pya;
    b_p2   <= a_pxa * a_d;
  end

  assign diff   = 67'(b_p1) - 67'(b_p2);
  assign toggle = b_vld && b_cond && (b_dpos ? (diff > 67'sd0) : diff[66]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      in_zone <= 1'b0;
    end else begin
      a_vld <= edge_in.vld;
      b_vld <= a_vld;
      if (clear) begin
        in_zone <= 1'b0;
      end else if (toggle) begin
        in_zone <= !in_zone;
      end
    end
  end

endmodule

@@ hw/rtl/oneway_zone_blocker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneway_zone_blocker
// Quadrilateral zone table with one-way direction blocking and point queries.
// ----------------------------------------------------------------------------
// Table writes and the blocked-id request complete as they are accepted. A
// robot update visits each zone in use (four corner reads from the
// single-port corner memory feeding a three-stage crossing pipeline) and
// emits one status result per zone. A point query visits the zones in turn
// and stops at the first blocked zone that contains the point. A new request
// is taken once the previous one has loaded its last result into the result
// register.
module oneway_zone_blocker #(
  parameter int MAX_ZONES = 16
) (
  input  logic             clk,
  input  logic             rst,
  owzb_cmd_if.sink         cmd,
  owzb_res_if.source       res,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata
);
  import owzb_pkg::*;

  localparam int ZW  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int LIM = (MAX_ZONES < 16) ? MAX_ZONES : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [63:0] corner_mem [MAX_ZONES*CORNERS];
  logic [63:0] entry_mem  [MAX_ZONES];
  logic [63:0] exit_mem   [MAX_ZONES];
  logic [1:0]  mode_mem   [MAX_ZONES];

  logic [1:0]        state;
  logic [4:0]        zone_count;
  logic signed [7:0] req_id;
  logic [15:0]       dir_flags;
  logic [3:0]        idx;
  logic [3:0]        step;
  logic [4:0]        nz;
  logic              op_query;
  coord_t            px, py;

  logic [63:0] corner_q, first_c, prev_c;
  logic [63:0] entry_q, exit_q;
  logic [1:0]  mode_q;

  logic               zero_axis;
  logic signed [33:0] sx, sy;
  logic signed [32:0] dx, dy;
  logic signed [66:0] prod_x, prod_y;
  logic signed [67:0] proj;
  logic               dir_pos, dir_neg;

  logic       p_kind, p_blocked, p_lethal, p_last;
  logic [3:0] p_zone;

  logic       accept, zone_ok, last_zone, flag, zblk, hit, in_zone;
  logic [4:0] n_use;
  logic [1:0] rd_corner;
  edge_in_t   edge_in;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign zone_ok   = 32'(cmd.zone) < MAX_ZONES;
  assign n_use     = (zone_count > 5'(LIM)) ? 5'(LIM) : zone_count;
  assign last_zone = (5'(idx) + 5'd1) == nz;
  assign rd_corner = step[1:0] - 2'd1;

  // table writes
  always_ff @(posedge clk) begin
    if (accept && zone_ok) begin
      unique case (cmd.command)
        CMD_CORNER: corner_mem[{ZW'(cmd.zone), cmd.corner}] <= {cmd.coord_x, cmd.coord_y};
        CMD_ENTRY:  entry_mem[ZW'(cmd.zone)] <= {cmd.coord_x, cmd.coord_y};
        CMD_EXIT:   exit_mem[ZW'(cmd.zone)]  <= {cmd.coord_x, cmd.coord_y};
        CMD_MODE:   mode_mem[ZW'(cmd.zone)]  <= cmd.mode;
        default: ;
      endcase
    end
  end

  // table reads
  always_ff @(posedge clk) begin
    if (state == ST_RUN && step < 4'd4) begin
      corner_q <= corner_mem[{ZW'(idx), rd_corner}];
    end
    if (state == ST_RUN && step == 4'd0) begin
      entry_q <= entry_mem[ZW'(idx)];
      exit_q  <= exit_mem[ZW'(idx)];
      mode_q  <= mode_mem[ZW'(idx)];
    end
    if (step == 4'd1) begin
      first_c <= corner_q;
    end
    if (step >= 4'd1 && step <= 4'd4) begin
      prev_c <= corner_q;
    end
  end

  always_comb begin
    edge_in.vld = (state == ST_RUN) && step >= 4'd2 && step <= 4'd5;
    edge_in.ax  = (step == 4'd5) ? $signed(first_c[63:32]) : $signed(corner_q[63:32]);
    edge_in.ay  = (step == 4'd5) ? $signed(first_c[31:0])  : $signed(corner_q[31:0]);
    edge_in.bx  = $signed(prev_c[63:32]);
    edge_in.by  = $signed(prev_c[31:0]);
    edge_in.px  = px;
    edge_in.py  = py;
  end

  owzb_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .clear   (state == ST_RUN && step == 4'd0),
    .edge_in (edge_in),
    .in_zone (in_zone)
  );

  // projection onto the entry-to-exit axis
  always_ff @(posedge clk) begin
    dx        <= 33'($signed(exit_q[63:32])) - 33'($signed(entry_q[63:32]));
    dy        <= 33'($signed(exit_q[31:0]))  - 33'($signed(entry_q[31:0]));
    zero_axis <= (exit_q == entry_q);
    sx        <= 34'($signed({px, 1'b0})) -
                 34'(33'($signed(entry_q[63:32])) + 33'($signed(exit_q[63:32])));
    sy        <= 34'($signed({py, 1'b0})) -
                 34'(33'($signed(entry_q[31:0])) + 33'($signed(exit_q[31:0])));
    prod_x    <= sx * dx;
    prod_y    <= sy * dy;
    dir_pos   <= proj > 68'sd0;
    dir_neg   <= proj[67];
  end

  assign proj = 68'(prod_x) + 68'(prod_y);
  assign flag = (mode_q == MODE_FWD || mode_q == MODE_REV) && !in_zone &&
                (zero_axis || ((mode_q == MODE_FWD) ? dir_pos : dir_neg));
  assign zblk = dir_flags[idx] || (req_id == {4'b0000, idx});
  assign hit  = zblk && in_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      zone_count <= 5'd0;
      req_id     <= -8'sd1;
      dir_flags  <= '0;
      res.valid  <= 1'b0;
      idx        <= '0;
      step       <= '0;
    end else begin
      if (cfg_we) begin
        zone_count <= cfg_wdata;
      end
      if (res.valid && res.ready && state != ST_PUSH) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            px       <= cmd.coord_x;
            py       <= cmd.coord_y;
            nz       <= n_use;
            idx      <= '0;
            step     <= '0;
            op_query <= (cmd.command == CMD_QUERY);
            if (cmd.command == CMD_BLOCK) begin
              req_id <= cmd.blocked_id;
            end
            if (cmd.command == CMD_UPDATE && n_use != 5'd0) begin
              state <= ST_RUN;
            end
            if (cmd.command == CMD_QUERY) begin
              if (n_use != 5'd0) begin
                state <= ST_RUN;
              end else begin
                p_kind    <= KIND_QUERY;
                p_zone    <= '0;
                p_blocked <= 1'b0;
                p_lethal  <= 1'b0;
                p_last    <= 1'b1;
                state     <= ST_PUSH;
              end
            end
          end
        end
        ST_RUN: begin
          if (step != 4'd8) begin
            step <= step + 4'd1;
          end else if (!op_query) begin
            dir_flags[idx] <= flag;
            p_kind    <= KIND_STATUS;
            p_zone    <= idx;
            p_blocked <= flag || (req_id == {4'b0000, idx});
            p_lethal  <= 1'b0;
            p_last    <= last_zone;
            state     <= ST_PUSH;
          end else if (hit || last_zone) begin
            p_kind    <= KIND_QUERY;
            p_zone    <= hit ? idx : 4'd0;
            p_blocked <= hit;
            p_lethal  <= hit;
            p_last    <= 1'b1;
            state     <= ST_PUSH;
          end else begin
            idx  <= idx + 4'd1;
            step <= '0;
          end
        end
        ST_PUSH: begin
          if (!res.valid || res.ready) begin
            res.valid      <= 1'b1;
            res.kind       <= p_kind;
            res.zone_index <= p_zone;
            res.blocked    <= p_blocked;
            res.lethal     <= p_lethal;
            res.last       <= p_last;
            step           <= '0;
            if (p_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/owzb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owzb_checker
// Port-level checks on the result channel of the one-way zone blocker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owzb_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic res_kind,
  input logic res_blocked,
  input logic res_lethal,
  input logic res_last
);
  import owzb_pkg::*;

  `OWZB_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped")
  `OWZB_ASSERT_IMPLY(a_qry_last, clk, rst, res_valid && res_kind == KIND_QUERY, res_last, "query not last")
  `OWZB_ASSERT_IMPLY(a_qry_eq, clk, rst, res_valid && res_kind == KIND_QUERY, res_blocked == res_lethal, "query mismatch")
  `OWZB_ASSERT_IMPLY(a_upd_leth, clk, rst, res_valid && res_kind == KIND_STATUS, !res_lethal, "status lethal")

endmodule

bind oneway_zone_blocker owzb_checker u_owzb_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_kind    (res.kind),
  .res_blocked (res.blocked),
  .res_lethal  (res.lethal),
  .res_last    (res.last)
);
